// ===== rtl/lrs_pkg.sv =====
// Package for the longest repeating subsequence block.
// Holds sizing constants, the sequencer state type and the result saturation function.
// No dependencies.
package lrs_pkg;

    // Longest string that is stored; later bytes are dropped.
    localparam int MAX_LEN = 256;

    localparam int ADDR_W = $clog2(MAX_LEN);       // byte / column / row index
    localparam int CNT_W  = $clog2(MAX_LEN + 1);   // byte count, can hold MAX_LEN
    localparam int VAL_W  = $clog2(MAX_LEN);       // table cell, at most MAX_LEN - 1
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_SETUP,
        ST_ROW_LOAD,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } lrs_state_t;

    // Clamp a table value to the 8-bit result field.
    function automatic logic [LEN_W-1:0] sat_len(input logic [VAL_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide > 32'd255)
        begin
            sat_len = '1;
        end
        else
        begin
            sat_len = wide[LEN_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/lrs_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module lrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/longest_repeating_subsequence_top.sv =====
// Longest repeating subsequence. A non-final byte is taken without holding off the input.
// The final byte starts a table run over n rows of n cells, n the stored length; each row
// passes through row setup and row load, then computes one cell per cycle; the run ends
// with a drain step and a done state, held while an earlier result is still stalled.
// Reset (rst_n, async, active low) clears the sequencer, byte count, overflow flag and output
// valid; the RAMs are not cleared: the byte store is read only below the count, and the first
// row treats the previous row as all zeros, so no clearing pass is needed.
module longest_repeating_subsequence_top
    import lrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              last,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [LEN_W-1:0]  repeat_length,
    output logic              overflow
);

    // Sequencer
    lrs_state_t state_reg, state_next;

    // Load side
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;       // bytes dropped in the string being loaded
    logic              run_ovf_reg;   // overflow flag of the string under evaluation
    logic [ADDR_W-1:0] last_idx_reg;  // n - 1 for the run

    // Table walk: issue stage
    logic [ADDR_W-1:0] row_reg;
    logic [ADDR_W-1:0] col_reg;
    logic [CHAR_W-1:0] ci_reg;        // byte of the current row

    // Table walk: compute stage, registered alongside the RAM read data
    logic              s2_valid_reg;
    logic [ADDR_W-1:0] s2_col_reg;
    logic [ADDR_W-1:0] s2_row_reg;
    logic [VAL_W-1:0]  left_reg;      // cell just computed in this row
    logic [VAL_W-1:0]  diag_reg;      // previous row, one column back

    // Output register
    logic              out_valid_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_ovf_reg;

    // RAM hookup
    logic              byte_wr_en;
    logic [ADDR_W-1:0] byte_addr;
    logic [CHAR_W-1:0] byte_rdata;
    logic [VAL_W-1:0]  row_rdata;

    logic              in_acc;
    logic              full;
    logic              out_free;

    // Compute stage values
    logic [VAL_W-1:0]  up_val;
    logic [VAL_W-1:0]  left_val;
    logic [VAL_W-1:0]  diag_val;
    logic              cell_match;
    logic [VAL_W-1:0]  cell_val;

    assign in_acc   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(MAX_LEN));
    assign out_free = !out_valid_reg || !out_stall;

    // Byte store: written while loading, read by the sequencer during the run.
    lrs_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_wr_en),
        .wr_addr (byte_addr),
        .wr_data (char_in),
        .rd_addr (byte_addr),
        .rd_data (byte_rdata)
    );

    // Table row: read at the issue column, written back from the compute stage.
    lrs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LEN)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (s2_valid_reg),
        .wr_addr (s2_col_reg),
        .wr_data (cell_val),
        .rd_addr (col_reg),
        .rd_data (row_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && last)
                begin
                    state_next = ST_ROW_SETUP;
                end
            end
            ST_ROW_SETUP:
            begin
                state_next = ST_ROW_LOAD;
            end
            ST_ROW_LOAD:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (col_reg == last_idx_reg)
                begin
                    state_next = (row_reg == last_idx_reg) ? ST_DRAIN : ST_ROW_SETUP;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs: handshake and byte RAM port
    always_comb
    begin
        in_stall   = 1'b1;
        byte_wr_en = 1'b0;
        byte_addr  = col_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // Store the byte at the count; a full store drops it.
                in_stall   = 1'b0;
                byte_wr_en = in_valid && !full;
                byte_addr  = count_reg[ADDR_W-1:0];
            end
            ST_ROW_SETUP:
            begin
                // Fetch the row's own byte.
                byte_addr = row_reg;
            end
            default:
            begin
                byte_addr = col_reg;
            end
        endcase
    end

    // Cell update. The first row sees an all-zero previous row, and column zero sees zero
    // to its left and on its diagonal.
    always_comb
    begin
        up_val     = (s2_row_reg == '0) ? '0 : row_rdata;
        left_val   = (s2_col_reg == '0) ? '0 : left_reg;
        diag_val   = (s2_col_reg == '0) ? '0 : diag_reg;
        cell_match = (ci_reg == byte_rdata) && (s2_row_reg != s2_col_reg);
        if (cell_match)
        begin
            cell_val = diag_val + VAL_W'(1);
        end
        else
        begin
            cell_val = (up_val > left_val) ? up_val : left_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s2_valid_reg <= (state_reg == ST_RUN);

            // Load: advance the count or flag the dropped byte; the final byte hands the
            // string over to the run and resets the load side at once.
            if (in_acc)
            begin
                if (last)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end

            // Output register: load when the run is done, else drop on a taken transaction.
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc && last)
        begin
            run_ovf_reg  <= ovf_reg || full;
            last_idx_reg <= full ? ADDR_W'(MAX_LEN - 1) : count_reg[ADDR_W-1:0];
            row_reg      <= '0;
        end

        if (state_reg == ST_ROW_LOAD)
        begin
            ci_reg  <= byte_rdata;
            col_reg <= '0;
        end

        if (state_reg == ST_RUN)
        begin
            col_reg <= col_reg + ADDR_W'(1);
            if (col_reg == last_idx_reg && row_reg != last_idx_reg)
            begin
                row_reg <= row_reg + ADDR_W'(1);
            end
        end

        s2_col_reg <= col_reg;
        s2_row_reg <= row_reg;

        if (s2_valid_reg)
        begin
            left_reg <= cell_val;
            diag_reg <= up_val;
        end

        // The last cell of the last row is the corner value.
        if (state_reg == ST_DONE && out_free)
        begin
            out_len_reg <= sat_len(left_reg);
            out_ovf_reg <= run_ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign repeat_length = out_len_reg;
    assign overflow      = out_ovf_reg;

endmodule

// ===== rtl/lrs_checker.sv =====
// Port-level checker for the longest repeating subsequence block, bound to the top level.
// Depends on lrs_pkg and longest_repeating_subsequence_top.
module lrs_assertions
    import lrs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              last,
    input logic              out_valid,
    input logic              out_stall,
    input logic [LEN_W-1:0]  repeat_length,
    input logic              overflow
);

    // A stalled result stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result holds its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(repeat_length) && $stable(overflow))
        else $error("stalled result changed");

    // The final byte starts the table run, which holds off the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("input not held off after final byte");

    // A non-final byte leaves the input free to take the next byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last |=> !in_stall)
        else $error("input stalled after a non-final byte");

    // A new result only appears at the end of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a run");

endmodule

bind longest_repeating_subsequence_top lrs_assertions u_lrs_assertions (.*);
